FILE: rtl/core/fci_pkg.sv
// Shared types, constants and constant functions of the fade curve interpolator.
// The constant functions build the curve ROM contents at elaboration.
// No dependencies.
package fci_pkg;

	localparam int LEVEL_W = 18;
	localparam int GAIN_W = 17;
	localparam int FRAC_W = 16;
	localparam int SEL_W = 3;
	localparam int NUM_CURVES = 7;

	typedef logic [GAIN_W-1:0] gain_t;
	typedef logic [FRAC_W-1:0] frac_t;
	typedef logic [SEL_W-1:0] sel_t;
	typedef logic [63:0] wide_t;

	localparam sel_t CURVE_LIN = 3'd0;
	localparam sel_t CURVE_POW075 = 3'd1;
	localparam sel_t CURVE_SQRT = 3'd2;
	localparam sel_t CURVE_QUARTIC = 3'd3;
	localparam sel_t CURVE_SINE = 3'd4;
	localparam sel_t CURVE_SINE15 = 3'd5;
	localparam sel_t CURVE_SINE2 = 3'd6;
	localparam sel_t CURVE_LAST = CURVE_SINE2;
	localparam sel_t CURVE_RESET = CURVE_SINE;

	localparam logic [LEVEL_W-2:0] LEVEL_ONE = 17'd65536;
	localparam wide_t Q30_ONE = 64'd1073741824;
	localparam wide_t HALF_PI_Q30 = 64'd1686629713;

	function automatic wide_t isqrt64(input wide_t v_in);
		wide_t v;
		wide_t r;
		wide_t bm;
		v = v_in;
		r = '0;
		bm = 64'h1 << 62;
		while (bm > v)
			bm = bm >> 2;
		while (bm != '0) begin
			if (v >= r + bm) begin
				v = v - (r + bm);
				r = (r >> 1) + bm;
			end else begin
				r = r >> 1;
			end
			bm = bm >> 2;
		end
		return r;
	endfunction

	function automatic wide_t sqrt_q30(input wide_t v);
		return isqrt64(v << 30);
	endfunction

	function automatic gain_t to_q16(input wide_t v);
		wide_t e;
		e = (v + 64'd8192) >> 14;
		return (e > 64'd65536) ? gain_t'(65536) : gain_t'(e);
	endfunction

	function automatic wide_t sub_floor(input wide_t sum, input wide_t term);
		return (term > sum) ? '0 : sum - term;
	endfunction

	function automatic wide_t sine_q30(input wide_t theta);
		wide_t t2;
		wide_t term;
		wide_t sum;
		t2 = (theta * theta) >> 30;
		sum = theta;
		term = ((theta * t2) >> 30) / 6;
		sum = sub_floor(sum, term);
		term = ((term * t2) >> 30) / 20;
		sum = sum + term;
		term = ((term * t2) >> 30) / 42;
		sum = sub_floor(sum, term);
		term = ((term * t2) >> 30) / 72;
		sum = sum + term;
		term = ((term * t2) >> 30) / 110;
		sum = sub_floor(sum, term);
		term = ((term * t2) >> 30) / 156;
		sum = sum + term;
		term = ((term * t2) >> 30) / 210;
		sum = sub_floor(sum, term);
		return (sum > Q30_ONE) ? Q30_ONE : sum;
	endfunction

	function automatic gain_t curve_entry(input sel_t curve, input wide_t x, input wide_t theta,
			input wide_t lin, input wide_t sq_arg);
		wide_t y;
		wide_t s;
		gain_t e;
		y = (x * x) >> 30;
		s = sine_q30(theta);
		unique case (curve)
			CURVE_LIN: e = gain_t'(lin);
			CURVE_POW075: e = to_q16(sqrt_q30((x * sqrt_q30(x)) >> 30));
			CURVE_SQRT: e = gain_t'((isqrt64(sq_arg) + 64'd1) >> 1);
			CURVE_QUARTIC: e = to_q16((y * y) >> 30);
			CURVE_SINE15: e = to_q16((s * sqrt_q30(s)) >> 30);
			CURVE_SINE2: e = to_q16((s * s) >> 30);
			default: e = to_q16(s);
		endcase
		return e;
	endfunction

endpackage

FILE: rtl/core/fci_rom.sv
// One bank (even or odd entries) of all curve tables, with registered read.
// Contents come from the fci_pkg constant functions at elaboration.
module fci_rom import fci_pkg::*; #(
	parameter int TABLE_SIZE = 512,
	parameter int BANK = 0,
	localparam int ROW_DEPTH = TABLE_SIZE / 2 + 1,
	localparam int AW = $clog2(ROW_DEPTH),
	localparam int ROM_DEPTH = NUM_CURVES * ROW_DEPTH,
	localparam int RAW = $clog2(ROM_DEPTH)
) (
	input  logic          clk,
	input  logic          rd_en,
	input  sel_t          sel,
	input  logic [AW-1:0] addr,
	output gain_t         data_q
);

	gain_t rom_mem [ROM_DEPTH];
	logic [RAW-1:0] rd_idx;

	for (genvar c = 0; c < NUM_CURVES; c++) begin : g_curve
		for (genvar k = 0; k < ROW_DEPTH; k++) begin : g_entry
			if (2 * k + BANK <= TABLE_SIZE) begin : g_used
				localparam wide_t IDX = 64'(2 * k + BANK);
				localparam wide_t X = (IDX << 30) / TABLE_SIZE;
				localparam wide_t THETA = (IDX * HALF_PI_Q30) / TABLE_SIZE;
				localparam wide_t LIN = (IDX * 64'd65536 + 64'(TABLE_SIZE / 2)) / TABLE_SIZE;
				localparam wide_t SQ_ARG = (IDX << 34) / TABLE_SIZE;
				assign rom_mem[c * ROW_DEPTH + k] = curve_entry(sel_t'(c), X, THETA, LIN, SQ_ARG);
			end else begin : g_pad
				assign rom_mem[c * ROW_DEPTH + k] = '0;
			end
		end
	end

	assign rd_idx = RAW'(sel) * RAW'(ROW_DEPTH) + RAW'(addr);

	always_ff @(posedge clk) begin
		if (rd_en)
			data_q <= rom_mem[rd_idx];
	end

endmodule

FILE: rtl/core/fci_pos.sv
// Stage 1: clamp the fade position and scale it into a table index and fraction.
// Depends on fci_pkg.
module fci_pos import fci_pkg::*; #(
	parameter int TABLE_SIZE = 512,
	localparam int IW = $clog2(TABLE_SIZE)
) (
	input  logic               clk,
	input  logic               adv_s1,
	input  logic [LEVEL_W-1:0] level,
	input  sel_t               sel,
	output logic [IW-1:0]      idx_s1,
	output frac_t              frac_s1,
	output sel_t               sel_s1
);

	localparam int PW = FRAC_W + IW;

	logic [LEVEL_W-2:0] pos;
	logic [PW-1:0] prod;
	logic [IW-1:0] idx;
	frac_t frac;

	always_comb begin
		priority if (level[LEVEL_W-1])
			pos = '0;
		else if (level[LEVEL_W-2:0] > LEVEL_ONE)
			pos = LEVEL_ONE;
		else
			pos = level[LEVEL_W-2:0];
	end

	assign prod = PW'(pos[FRAC_W-1:0]) * PW'(TABLE_SIZE);

	always_comb begin
		if (pos[FRAC_W]) begin
			idx = IW'(TABLE_SIZE - 1);
			frac = '1;
		end else begin
			idx = prod[PW-1:FRAC_W];
			frac = prod[FRAC_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			idx_s1 <= idx;
			frac_s1 <= frac;
			sel_s1 <= sel;
		end
	end

endmodule

FILE: rtl/core/fci_lerp.sv
// Stages 3 and 4: order the two entries, scale their difference, round and apply.
// Depends on fci_pkg.
module fci_lerp import fci_pkg::*; (
	input  logic  clk,
	input  logic  adv_s3,
	input  logic  adv_s4,
	input  gain_t even_s2,
	input  gain_t odd_s2,
	input  logic  odd_s2_sel,
	input  frac_t frac_s2,
	output gain_t gain_s4
);

	localparam int PW = GAIN_W + FRAC_W;

	gain_t a;
	gain_t b;
	gain_t diff;
	logic up;
	gain_t a_s3;
	logic up_s3;
	logic [PW-1:0] prod_s3;
	logic [PW-1:0] rnd;
	gain_t d;

	assign a = odd_s2_sel ? odd_s2 : even_s2;
	assign b = odd_s2_sel ? even_s2 : odd_s2;
	assign up = (b >= a);
	assign diff = up ? b - a : a - b;

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			a_s3 <= a;
			up_s3 <= up;
			prod_s3 <= PW'(diff) * PW'(frac_s2);
		end
	end

	assign rnd = prod_s3 + PW'(32768);
	assign d = GAIN_W'(rnd >> FRAC_W);

	always_ff @(posedge clk) begin
		if (adv_s4)
			gain_s4 <= up_s3 ? a_s3 + d : a_s3 - d;
	end

endmodule

FILE: rtl/core/fade_curve_interpolator_unit.sv
// Top level of the fade curve interpolator: curve select register, valid chain, banks.
// Depends on fci_pkg, fci_pos, fci_rom, fci_lerp.
//
//   channel | signals                     | direction
//   in      | in_valid, in_ready, level   | item in, level Q2.16 signed
//   out     | out_valid, out_ready, gain  | item out, gain Q1.16 unsigned
//   cfg     | cfg_valid, cfg_ready, curve_select | register write, always ready
//
// One item per cycle sustained while out_ready is high; the stages are position, bank read, multiply, round.
// Neighboring entries come from an even and an odd ROM bank read in the same cycle.
// Reset clears the valid chain and sets the curve to sine.
// Each stage holds only while it is full and the stage after it holds.
module fade_curve_interpolator_unit import fci_pkg::*; #(
	parameter int TABLE_SIZE = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [LEVEL_W-1:0] level,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [GAIN_W-1:0]  gain,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [SEL_W-1:0]   curve_select
);

	localparam int IW = $clog2(TABLE_SIZE);
	localparam int AW = $clog2(TABLE_SIZE / 2 + 1);

	sel_t curve_select_q;
	sel_t sel_eff;
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic adv_s1, adv_s2, adv_s3, adv_s4;
	logic [IW-1:0] idx_s1;
	frac_t frac_s1;
	sel_t sel_s1;
	logic [AW-1:0] even_addr;
	logic [AW-1:0] odd_addr;
	logic [IW:0] idx_inc;
	gain_t even_s2;
	gain_t odd_s2;
	logic odd_s2_sel;
	frac_t frac_s2;
	gain_t gain_s4;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			curve_select_q <= CURVE_RESET;
		else if (cfg_valid)
			curve_select_q <= curve_select;
	end

	assign sel_eff = (curve_select_q > CURVE_LAST) ? CURVE_SINE : curve_select_q;

	assign adv_s4 = !valid_s4 || out_ready;
	assign adv_s3 = !valid_s3 || adv_s4;
	assign adv_s2 = !valid_s2 || adv_s3;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv_s1)
				valid_s1 <= in_valid;
			if (adv_s2)
				valid_s2 <= valid_s1;
			if (adv_s3)
				valid_s3 <= valid_s2;
			if (adv_s4)
				valid_s4 <= valid_s3;
		end
	end

	fci_pos #(.TABLE_SIZE(TABLE_SIZE)) u_pos (
		.clk(clk),
		.adv_s1(adv_s1),
		.level(level),
		.sel(sel_eff),
		.idx_s1(idx_s1),
		.frac_s1(frac_s1),
		.sel_s1(sel_s1)
	);

	assign idx_inc = {1'b0, idx_s1} + (IW + 1)'(1);
	assign even_addr = AW'(idx_inc >> 1);
	assign odd_addr = AW'(idx_s1 >> 1);

	fci_rom #(.TABLE_SIZE(TABLE_SIZE), .BANK(0)) u_rom_even (
		.clk(clk),
		.rd_en(adv_s2),
		.sel(sel_s1),
		.addr(even_addr),
		.data_q(even_s2)
	);

	fci_rom #(.TABLE_SIZE(TABLE_SIZE), .BANK(1)) u_rom_odd (
		.clk(clk),
		.rd_en(adv_s2),
		.sel(sel_s1),
		.addr(odd_addr),
		.data_q(odd_s2)
	);

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			odd_s2_sel <= idx_s1[0];
			frac_s2 <= frac_s1;
		end
	end

	fci_lerp u_lerp (
		.clk(clk),
		.adv_s3(adv_s3),
		.adv_s4(adv_s4),
		.even_s2(even_s2),
		.odd_s2(odd_s2),
		.odd_s2_sel(odd_s2_sel),
		.frac_s2(frac_s2),
		.gain_s4(gain_s4)
	);

	assign out_valid = valid_s4;
	assign gain = gain_s4;

endmodule
